### rtl/pvtr_pkg.sv
// types, register indexes and constants of the peep valve time regulator
`timescale 1ns / 1ps

package pvtr_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_TARGET_PEEP = 2'd0;
  localparam logic [1:0] REG_RESP_RATE   = 2'd1;
  localparam logic [1:0] REG_INSP_TIME   = 2'd2;

  // configuration reset values
  localparam logic [7:0]  TARGET_PEEP_RST = 8'd5;
  localparam logic [6:0]  RESP_RATE_RST   = 7'd12;
  localparam logic [15:0] INSP_TIME_RST   = 16'd1000;

  // mode thresholds
  localparam logic [6:0]  FAST_RATE      = 7'd30;
  localparam logic [15:0] SHORT_INSP_MAX = 16'd700;

  // open time limits
  localparam logic [10:0] OPEN_TIME_MAX = 11'd700;
  localparam logic [9:0]  OPEN_TIME_MIN = 10'd1;

  // step sizes
  localparam logic [6:0] UP_LARGE   = 7'd100;
  localparam logic [6:0] UP_MEDIUM  = 7'd40;
  localparam logic [6:0] UP_SMALL   = 7'd10;
  localparam logic [5:0] DOWN_LARGE = 6'd50;
  localparam logic [5:0] DOWN_MED   = 6'd30;
  localparam logic [5:0] DOWN_SMALL = 6'd10;

  // band edges around the target
  localparam logic [8:0] BAND_WIDE   = 9'd8;
  localparam logic [8:0] BAND_NARROW = 9'd2;

  // trim limits
  localparam logic [7:0] TRIM_FLOOR = 8'd3;
  localparam logic [7:0] TRIM_MAX   = 8'd255;

  // fast mode wait count at which a step is taken
  localparam logic [1:0] FAST_WAIT_GO = 2'd3;

  typedef struct packed {
    logic [7:0]  target_peep;
    logic [6:0]  resp_rate;
    logic [15:0] inspiration_time_ms;
  } cfg_t;

  typedef struct packed {
    logic [7:0] peep_trim;
    logic [1:0] slow_low_wait;
    logic [1:0] fast_high_wait;
    logic [1:0] fast_low_wait;
  } state_t;

  typedef struct packed {
    logic up;
    logic down;
    logic taken;
  } step_info_t;

endpackage

### rtl/pvtr_req_if.sv
// request channel carrying one breath measurement
`timescale 1ns / 1ps

interface pvtr_req_if;
  logic       valid;
  logic       ready;
  logic [7:0] measured_peep;
  logic [7:0] peak_peep;
  logic [9:0] open_time;

  modport source (output valid, measured_peep, peak_peep, open_time, input ready);
  modport sink (input valid, measured_peep, peak_peep, open_time, output ready);
endinterface

### rtl/pvtr_rsp_if.sv
// result channel carrying the adjusted open time and trim
`timescale 1ns / 1ps

interface pvtr_rsp_if;
  logic       valid;
  logic       ready;
  logic [9:0] new_open_time;
  logic [7:0] peep_trim;

  modport source (output valid, new_open_time, peep_trim, input ready);
  modport sink (input valid, new_open_time, peep_trim, output ready);
endinterface

### rtl/pvtr_step.sv
// single step logic: band selection, wait counters, open time and trim update
`timescale 1ns / 1ps

module pvtr_step (
  input  pvtr_pkg::cfg_t       cfg,
  input  pvtr_pkg::state_t     st,
  input  logic [7:0]           measured_peep,
  input  logic [7:0]           peak_peep,
  input  logic [9:0]           open_time,
  output pvtr_pkg::state_t     st_next,
  output logic [9:0]           new_open_time,
  output pvtr_pkg::step_info_t info
);

  logic        fast;
  logic [7:0]  p;
  logic [8:0]  p9;
  logic [8:0]  tg9;
  logic        up_l, up_m, up_s, zero_band, dn_l, dn_m, dn_s;
  logic [6:0]  inc;
  logic [5:0]  dec;
  logic        is_up, is_down;
  logic [10:0] sum;
  logic [10:0] diff;
  logic        clamp;
  logic        sat;
  logic [1:0]  cnt;
  logic        go;

  // mode and choice of the pressure used
  assign fast = cfg.resp_rate >= pvtr_pkg::FAST_RATE;
  assign p    = (fast && (cfg.inspiration_time_ms <= pvtr_pkg::SHORT_INSP_MAX)) ?
                peak_peep : measured_peep;
  assign p9   = {1'b0, p};
  assign tg9  = {1'b0, cfg.target_peep};

  // band compares, lower edges written without going negative
  assign up_l      = p9 > (tg9 + pvtr_pkg::BAND_WIDE);
  assign up_m      = p9 > (tg9 + pvtr_pkg::BAND_NARROW);
  assign up_s      = p9 > tg9;
  assign zero_band = (p == 8'd0) && !up_s;
  assign dn_l      = (p9 + pvtr_pkg::BAND_WIDE) < tg9;
  assign dn_m      = (p9 + pvtr_pkg::BAND_NARROW) < tg9;
  assign dn_s      = p9 < tg9;

  // step size by band priority
  always_comb begin
    inc = 7'd0;
    dec = 6'd0;
    if (up_l) begin
      inc = pvtr_pkg::UP_LARGE;
    end else if (up_m) begin
      inc = pvtr_pkg::UP_MEDIUM;
    end else if (up_s) begin
      inc = pvtr_pkg::UP_SMALL;
    end else if (zero_band) begin
      dec = pvtr_pkg::DOWN_SMALL;
    end else if (dn_l) begin
      dec = pvtr_pkg::DOWN_LARGE;
    end else if (dn_m) begin
      dec = pvtr_pkg::DOWN_MED;
    end else if (dn_s) begin
      dec = pvtr_pkg::DOWN_SMALL;
    end
  end

  assign is_up   = up_s;
  assign is_down = !up_s && (zero_band || dn_s);

  // candidate open times
  assign sum   = {1'b0, open_time} + {4'd0, inc};
  assign diff  = {1'b0, open_time} - {5'd0, dec};
  assign clamp = ({1'b0, open_time} <= {5'd0, dec}) || (diff > pvtr_pkg::OPEN_TIME_MAX);
  assign sat   = fast ? (sum > pvtr_pkg::OPEN_TIME_MAX) : (sum >= pvtr_pkg::OPEN_TIME_MAX);

  // wait counters, open time and trim
  always_comb begin
    st_next       = st;
    new_open_time = open_time;
    cnt           = 2'd0;
    go            = 1'b0;
    if (is_up) begin
      go = 1'b1;
      if (fast) begin
        cnt                    = st.fast_high_wait + 2'd1;
        go                     = cnt == pvtr_pkg::FAST_WAIT_GO;
        st_next.fast_high_wait = go ? 2'd0 : cnt;
      end
      if (go) begin
        if (sat) begin
          new_open_time = pvtr_pkg::OPEN_TIME_MAX[9:0];
          if (st.peep_trim != 8'd0) begin
            st_next.peep_trim = st.peep_trim - 8'd1;
          end
        end else begin
          new_open_time = sum[9:0];
        end
      end
      if (st_next.peep_trim <= pvtr_pkg::TRIM_FLOOR) begin
        st_next.peep_trim = pvtr_pkg::TRIM_FLOOR;
      end
    end else if (is_down) begin
      if (fast) begin
        cnt                   = st.fast_low_wait + 2'd1;
        go                    = cnt == pvtr_pkg::FAST_WAIT_GO;
        st_next.fast_low_wait = go ? 2'd0 : cnt;
      end else begin
        cnt                   = st.slow_low_wait + 2'd1;
        go                    = zero_band ? (cnt > 2'd1) : (cnt > 2'd0);
        st_next.slow_low_wait = go ? 2'd0 : cnt;
      end
      if (go) begin
        new_open_time = clamp ? pvtr_pkg::OPEN_TIME_MIN : diff[9:0];
        if ((zero_band || clamp) && (st.peep_trim != pvtr_pkg::TRIM_MAX)) begin
          st_next.peep_trim = st.peep_trim + 8'd1;
        end
      end
    end
  end

  assign info.up    = is_up;
  assign info.down  = is_down;
  assign info.taken = go;

endmodule

### rtl/peep_valve_time_regulator_unit.sv
// top level: configuration, request register, step logic and result register
`timescale 1ns / 1ps

// One request per breath. A request is taken into an input register, goes
// through the step logic and moves into the result register, which raises
// rsp.valid, once that register is empty or its result is being taken. The
// block takes one request every cycle while results are taken; the trim and
// the wait counters are updated as each request moves into the result
// register, which keeps consecutive requests in order. A full result
// register that is not taken holds the request behind it in the input
// register, and then req.ready falls.
// Configuration is written through cfg_write, cfg_index and cfg_data.
module peep_valve_time_regulator_unit (
  input  logic              clk,
  input  logic              rst,
  pvtr_req_if.sink          req,
  pvtr_rsp_if.source        rsp,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data
);

  pvtr_pkg::cfg_t       cfg;
  pvtr_pkg::state_t     st;
  pvtr_pkg::state_t     st_next;
  pvtr_pkg::step_info_t info;

  logic       in_valid;
  logic [7:0] in_measured;
  logic [7:0] in_peak;
  logic [9:0] in_open;
  logic       out_valid;
  logic [9:0] out_open;
  logic [7:0] out_trim;
  logic [9:0] step_open;
  logic       advance;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_peep         <= pvtr_pkg::TARGET_PEEP_RST;
      cfg.resp_rate           <= pvtr_pkg::RESP_RATE_RST;
      cfg.inspiration_time_ms <= pvtr_pkg::INSP_TIME_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        pvtr_pkg::REG_TARGET_PEEP: cfg.target_peep         <= cfg_data[7:0];
        pvtr_pkg::REG_RESP_RATE:   cfg.resp_rate           <= cfg_data[6:0];
        pvtr_pkg::REG_INSP_TIME:   cfg.inspiration_time_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake between the two registers
  assign advance   = in_valid && (!out_valid || rsp.ready);
  assign req.ready = !in_valid || advance;

  // request register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_measured <= req.measured_peep;
      in_peak     <= req.peak_peep;
      in_open     <= req.open_time;
    end
  end

  // step logic
  pvtr_step u_step (
    .cfg           (cfg),
    .st            (st),
    .measured_peep (in_measured),
    .peak_peep     (in_peak),
    .open_time     (in_open),
    .st_next       (st_next),
    .new_open_time (step_open),
    .info          (info)
  );

  // regulator state, updated as a request completes
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_open <= step_open;
      out_trim <= st_next.peep_trim;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.new_open_time = out_open;
  assign rsp.peep_trim     = out_trim;

  // a completing request always shows up as a result on the next edge
  a_advance_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> rsp.valid)
    else $error("completed request did not reach the result register");

  // the input side only stalls behind a full, untaken result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> (in_valid && rsp.valid && !rsp.ready))
    else $error("request side stalled without a blocked result");

  // an upward band never leaves the trim below its floor
  a_trim_floor: assert property (@(posedge clk) disable iff (rst)
    (advance && info.up) |=> (rsp.peep_trim >= pvtr_pkg::TRIM_FLOOR))
    else $error("trim below floor after an upward band");

  // a step is only taken inside an upward or downward band
  a_step_band: assert property (@(posedge clk) disable iff (rst)
    (advance && info.taken) |-> (info.up || info.down))
    else $error("step taken outside any band");

  // wait counters clear when their step is taken
  a_wait_range: assert property (@(posedge clk) disable iff (rst)
    (st.fast_high_wait != pvtr_pkg::FAST_WAIT_GO) &&
    (st.fast_low_wait != pvtr_pkg::FAST_WAIT_GO) && (st.slow_low_wait <= 2'd1))
    else $error("wait counter out of range");

endmodule

### tb/peep_valve_time_regulator_unit_tb.sv
// self-checking testbench for the peep valve time regulator unit
`timescale 1ns / 1ps

module peep_valve_time_regulator_unit_tb;

  // one predicted result: adjusted open time and trim
  typedef struct packed {
    logic [9:0] open_time;
    logic [7:0] trim;
  } adjustment_t;

  // tracks regulator state and checks results in request order
  class valve_adjust_scoreboard;
    logic [7:0]  cfg_target;
    logic [6:0]  cfg_rate;
    logic [15:0] cfg_insp;
    logic [7:0]  trim;
    logic [1:0]  slow_low_wait;
    logic [1:0]  fast_high_wait;
    logic [1:0]  fast_low_wait;
    adjustment_t pending[$];
    int          mismatches;

    function new();
      cfg_target     = pvtr_pkg::TARGET_PEEP_RST;
      cfg_rate       = pvtr_pkg::RESP_RATE_RST;
      cfg_insp       = pvtr_pkg::INSP_TIME_RST;
      trim           = '0;
      slow_low_wait  = '0;
      fast_high_wait = '0;
      fast_low_wait  = '0;
      mismatches     = 0;
    endfunction

    function void write_register(logic [1:0] index, logic [15:0] data);
      case (index)
        pvtr_pkg::REG_TARGET_PEEP: cfg_target = data[7:0];
        pvtr_pkg::REG_RESP_RATE:   cfg_rate   = data[6:0];
        pvtr_pkg::REG_INSP_TIME:   cfg_insp   = data;
        default: ;
      endcase
    endfunction

    // one regulation step, updating trim and wait counters
    function adjustment_t predict_adjustment(logic [7:0] measured, logic [7:0] peak,
                                             logic [9:0] open_time);
      adjustment_t result;
      int used, tgt, t, step_size, wide, narrow, t_max, t_min;
      bit fast, rising, falling, zero_band, go, clamped;
      wide      = int'(pvtr_pkg::BAND_WIDE);
      narrow    = int'(pvtr_pkg::BAND_NARROW);
      t_max     = int'(pvtr_pkg::OPEN_TIME_MAX);
      t_min     = int'(pvtr_pkg::OPEN_TIME_MIN);
      used      = int'(measured);
      tgt       = int'(cfg_target);
      t         = int'(open_time);
      fast      = (cfg_rate >= pvtr_pkg::FAST_RATE);
      rising    = 1'b0;
      falling   = 1'b0;
      zero_band = 1'b0;
      go        = 1'b0;
      step_size = 0;
      // short inspiration in fast mode regulates on the peak
      if (fast && cfg_insp <= pvtr_pkg::SHORT_INSP_MAX) used = int'(peak);

      // band selection, first match wins
      if (used > tgt + wide) begin
        rising = 1'b1; step_size = int'(pvtr_pkg::UP_LARGE);
      end else if (used > tgt + narrow) begin
        rising = 1'b1; step_size = int'(pvtr_pkg::UP_MEDIUM);
      end else if (used > tgt) begin
        rising = 1'b1; step_size = int'(pvtr_pkg::UP_SMALL);
      end else if (used == 0) begin
        falling = 1'b1; zero_band = 1'b1; step_size = int'(pvtr_pkg::DOWN_SMALL);
      end else if (used < tgt - wide) begin
        falling = 1'b1; step_size = int'(pvtr_pkg::DOWN_LARGE);
      end else if (used < tgt - narrow) begin
        falling = 1'b1; step_size = int'(pvtr_pkg::DOWN_MED);
      end else if (used < tgt) begin
        falling = 1'b1; step_size = int'(pvtr_pkg::DOWN_SMALL);
      end

      if (rising) begin
        go = 1'b1;
        if (fast) begin
          fast_high_wait = fast_high_wait + 2'd1;
          go = (fast_high_wait == pvtr_pkg::FAST_WAIT_GO);
        end
        if (go) begin
          if (fast) fast_high_wait = '0;
          t = t + step_size;
          // slow mode saturates on reaching the limit, fast mode on passing it
          if (fast ? (t > t_max) : (t >= t_max)) begin
            t = t_max;
            if (trim != 8'd0) trim = trim - 8'd1;
          end
        end
        if (trim <= pvtr_pkg::TRIM_FLOOR) trim = pvtr_pkg::TRIM_FLOOR;
      end else if (falling) begin
        if (fast) begin
          fast_low_wait = fast_low_wait + 2'd1;
          go = (fast_low_wait == pvtr_pkg::FAST_WAIT_GO);
        end else begin
          slow_low_wait = slow_low_wait + 2'd1;
          go = zero_band ? (slow_low_wait > 2'd1) : (slow_low_wait > 2'd0);
        end
        if (go) begin
          if (fast) fast_low_wait = '0;
          else slow_low_wait = '0;
          t = t - step_size;
          clamped = (t < t_min) || (t > t_max);
          if (clamped) t = t_min;
          if ((zero_band || clamped) && trim != pvtr_pkg::TRIM_MAX) trim = trim + 8'd1;
        end
      end

      result.open_time = t[9:0];
      result.trim      = trim;
      return result;
    endfunction

    function void note_request(logic [7:0] measured, logic [7:0] peak, logic [9:0] open_time);
      pending.push_back(predict_adjustment(measured, peak, open_time));
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    function void check_result(logic [9:0] open_time, logic [7:0] trim_out);
      adjustment_t exp_adj;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result open_time=%0d trim=%0d", open_time, trim_out));
        return;
      end
      exp_adj = pending.pop_front();
      if (open_time !== exp_adj.open_time)
        report($sformatf("new_open_time expected %0d got %0d", exp_adj.open_time, open_time));
      if (trim_out !== exp_adj.trim)
        report($sformatf("peep_trim expected %0d got %0d", exp_adj.trim, trim_out));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  pvtr_req_if req_if ();
  pvtr_rsp_if rsp_if ();

  valve_adjust_scoreboard sb;

  bit receiver_idling = 1'b0;
  int results_hold_cycles = 0;

  peep_valve_time_regulator_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_if),
    .rsp       (rsp_if),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // watch both handshakes
  always @(posedge clk) begin
    if (!rst) begin
      if (req_if.valid && req_if.ready)
        sb.note_request(req_if.measured_peep, req_if.peak_peep, req_if.open_time);
      if (rsp_if.valid && rsp_if.ready)
        sb.check_result(rsp_if.new_open_time, rsp_if.peep_trim);
    end
  end

  // result side: ready runs, random stall bursts and the long hold-off
  initial begin : result_receiver
    int hold;
    rsp_if.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (results_hold_cycles != 0) begin
        hold = results_hold_cycles;
        rsp_if.ready <= 1'b0;
        repeat (hold) @(posedge clk);
        results_hold_cycles = 0;
      end else if (receiver_idling && $urandom_range(0, 4) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        rsp_if.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // offer one request and hold it until taken
  task automatic send_request(logic [7:0] measured, logic [7:0] peak, logic [9:0] open_time);
    req_if.valid         <= 1'b1;
    req_if.measured_peep <= measured;
    req_if.peak_peep     <= peak;
    req_if.open_time     <= open_time;
    do @(posedge clk); while (!req_if.ready);
  endtask

  // write all three registers, block idle
  task automatic set_ventilation(logic [7:0] target, logic [6:0] rate, logic [15:0] insp);
    cfg_write <= 1'b1;
    cfg_index <= pvtr_pkg::REG_TARGET_PEEP;
    cfg_data  <= {8'd0, target};
    @(posedge clk);
    sb.write_register(pvtr_pkg::REG_TARGET_PEEP, {8'd0, target});
    cfg_index <= pvtr_pkg::REG_RESP_RATE;
    cfg_data  <= {9'd0, rate};
    @(posedge clk);
    sb.write_register(pvtr_pkg::REG_RESP_RATE, {9'd0, rate});
    cfg_index <= pvtr_pkg::REG_INSP_TIME;
    cfg_data  <= insp;
    @(posedge clk);
    sb.write_register(pvtr_pkg::REG_INSP_TIME, insp);
    cfg_write <= 1'b0;
  endtask

  // sampled away from the rising edge so the last request is already noted
  task automatic wait_for_results();
    @(negedge clk);
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // pressure value mostly close to the target so every band is hit
  function automatic logic [7:0] pick_peep(int centre);
    int v;
    case ($urandom_range(0, 9))
      0: v = 0;
      1: v = int'($urandom_range(0, 255));
      default: v = centre + int'($urandom_range(0, 24)) - 12;
    endcase
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  function automatic logic [9:0] pick_open_time();
    case ($urandom_range(0, 11))
      0: return 10'($urandom_range(701, 1023));
      1: return 10'd0;
      2: return 10'd700;
      3: return 10'($urandom_range(650, 700));
      4: return 10'($urandom_range(1, 60));
      default: return 10'($urandom_range(0, 700));
    endcase
  endfunction

  task automatic run_random_requests(int count, bit idle_requests);
    for (int i = 0; i < count; i++) begin
      if (i > 0 && idle_requests && $urandom_range(0, 3) == 0) begin
        req_if.valid <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      send_request(pick_peep(int'(sb.cfg_target)), pick_peep(int'(sb.cfg_target)),
                   pick_open_time());
    end
    req_if.valid <= 1'b0;
  endtask

  // stimulus sequence
  initial begin : stimulus
    logic [7:0]  tgt;
    logic [6:0]  rate;
    logic [15:0] insp;
    bit          slow;
    bit          idle_requests;
    sb = new();
    req_if.valid         <= 1'b0;
    req_if.measured_peep <= '0;
    req_if.peak_peep     <= '0;
    req_if.open_time     <= '0;
    cfg_write            <= 1'b0;
    cfg_index            <= pvtr_pkg::REG_TARGET_PEEP;
    cfg_data             <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // slow mode at reset settings: every band but the large downward one, saturation and clamps
    send_request(8'd255, 8'd0, 10'd0);
    send_request(8'd9, 8'd255, 10'd650);
    send_request(8'd6, 8'd0, 10'd690);
    send_request(8'd0, 8'd255, 10'd5);
    send_request(8'd0, 8'd0, 10'd5);
    send_request(8'd1, 8'd0, 10'd20);
    send_request(8'd4, 8'd0, 10'd700);
    send_request(8'd5, 8'd0, 10'd1023);
    send_request(8'd200, 8'd0, 10'd1023);
    send_request(8'd1, 8'd0, 10'd1023);
    send_request(8'd13, 8'd0, 10'd600);
    req_if.valid <= 1'b0;
    wait_for_results();

    // fast mode on the peak with target zero: zero band and upper limit
    set_ventilation(8'd0, 7'd99, 16'd0);
    repeat (3) send_request(8'd255, 8'd0, 10'd30);
    repeat (3) send_request(8'd0, 8'd255, 10'd600);
    repeat (3) send_request(8'd0, 8'd255, 10'd650);
    req_if.valid <= 1'b0;
    wait_for_results();

    // fast mode threshold edges with the top target
    set_ventilation(8'd255, 7'd30, 16'd700);
    repeat (3) send_request(8'd0, 8'd254, 10'd15);
    repeat (3) send_request(8'd0, 8'd0, 10'd1023);
    req_if.valid <= 1'b0;
    wait_for_results();

    // random phases alternating slow and fast mode
    for (int ph = 0; ph < 9; ph++) begin
      slow = (ph % 2 == 0);
      case ($urandom_range(0, 5))
        0: tgt = 8'd0;
        1: tgt = 8'd255;
        2: tgt = 8'($urandom_range(0, 255));
        default: tgt = 8'($urandom_range(1, 30));
      endcase
      case ($urandom_range(0, 2))
        0: rate = slow ? 7'd0 : 7'd30;
        1: rate = slow ? 7'd29 : 7'd99;
        default: rate = slow ? 7'($urandom_range(1, 28)) : 7'($urandom_range(31, 98));
      endcase
      case ($urandom_range(0, 5))
        0: insp = 16'd0;
        1: insp = 16'd700;
        2: insp = 16'd701;
        3: insp = 16'd60000;
        4: insp = 16'($urandom_range(0, 700));
        default: insp = 16'($urandom_range(0, 60000));
      endcase
      set_ventilation(tgt, rate, insp);

      if (ph == 3) begin
        // long result hold-off while requests keep coming
        idle_requests       = 1'b0;
        receiver_idling     = 1'b0;
        results_hold_cycles = 120;
      end else if (ph < 7) begin
        idle_requests   = ($urandom_range(0, 3) != 0);
        receiver_idling = ($urandom_range(0, 3) != 0);
      end else begin
        idle_requests   = 1'b0;
        receiver_idling = 1'b0;
      end
      run_random_requests(72, idle_requests);
      wait_for_results();
    end

    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // run limit
  initial begin : watchdog
    #(3_000_000);
    $display("Regression FAIL");
    $finish;
  end

endmodule
